// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Fixed-point format, derived datapath widths and the structures that travel
// between the pipeline sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int OUT_W     = 16;
   localparam int LANES     = 4;

   localparam int PIV_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int MAG_W = PIV_W - 1;
   localparam int SQ_W  = MAG_W + FRAC_BITS;
   localparam int RT_W  = (SQ_W + 1) / 2;
   localparam int SP_W  = 2 * RT_W;
   localparam int Q_W   = OUT_W + 1;
   localparam int DW    = SQ_W + Q_W + 1;

   localparam logic signed [PIV_W-1:0] ONE = PIV_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << (OUT_W - 1);
   localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   typedef struct packed {
      logic                            degen;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0][MAG_W-1:0]     mag;
   } rmq_side_type;

   typedef struct packed {
      logic                            degen;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0]                ovf;
      logic [LANES-1:0][Q_W-1:0]       quo;
   } rmq_quo_type;

endpackage

// ===== src/rmq_if.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: channel interfaces
// Request channel carrying the matrix and response channel carrying the
// quaternion, each with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rmq_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m_r0c0;
   logic signed [15:0] m_r0c1;
   logic signed [15:0] m_r0c2;
   logic signed [15:0] m_r1c0;
   logic signed [15:0] m_r1c1;
   logic signed [15:0] m_r1c2;
   logic signed [15:0] m_r2c0;
   logic signed [15:0] m_r2c1;
   logic signed [15:0] m_r2c2;

   modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                   m_r2c0, m_r2c1, m_r2c2, input ready);
   modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                 m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface rmq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic               degenerate;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                   input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate,
                 output ready);
endinterface

// ===== src/rmq_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined integer square root
// One root bit per stage, with the component sideband carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_sqrt_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [rmq_pkg::SP_W-1:0]  in_s,
   input  rmq_pkg::rmq_side_type     in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [rmq_pkg::RT_W-1:0]  out_root,
   output rmq_pkg::rmq_side_type     out_side
);
   import rmq_pkg::*;

   typedef struct packed {
      rmq_side_type      side;
      logic [SP_W-1:0]   s;
      logic [RT_W:0]     rem;
      logic [RT_W-1:0]   root;
   } sq_stage_type;

   sq_stage_type st_ff [RT_W];
   sq_stage_type st_in [RT_W];
   logic         v_ff  [RT_W];
   logic         adv   [RT_W+1];

   always_comb begin
      adv[RT_W] = out_ready;
      for (int k = RT_W - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      sq_stage_type     src;
      logic [RT_W+2:0]  rem2;
      logic [RT_W+2:0]  trial;
      src.side = in_side;
      src.s    = in_s;
      src.rem  = '0;
      src.root = '0;
      for (int k = 0; k < RT_W; k++) begin
         rem2  = {src.rem, src.s[SP_W-1 -: 2]};
         trial = (RT_W + 3)'({src.root, 2'b01});
         st_in[k].side = src.side;
         st_in[k].s    = src.s << 2;
         if (rem2 >= trial) begin
            st_in[k].rem  = (RT_W + 1)'(rem2 - trial);
            st_in[k].root = {src.root[RT_W-2:0], 1'b1};
         end else begin
            st_in[k].rem  = (RT_W + 1)'(rem2);
            st_in[k].root = {src.root[RT_W-2:0], 1'b0};
         end
         src = st_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RT_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < RT_W; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RT_W; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[RT_W-1];
   assign out_root  = st_ff[RT_W-1].root;
   assign out_side  = st_ff[RT_W-1].side;

endmodule

// ===== src/rmq_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined four-lane divider
// Rounds each component magnitude over twice the root, one quotient bit per
// stage, with an overflow flag for quotients beyond the quotient width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [rmq_pkg::RT_W-1:0]  in_root,
   input  rmq_pkg::rmq_side_type     in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rmq_pkg::rmq_quo_type      out_quo
);
   import rmq_pkg::*;

   localparam int NS = Q_W + 1;

   typedef struct packed {
      logic                       degen;
      logic [LANES-1:0]           neg;
      logic [LANES-1:0]           ovf;
      logic [LANES-1:0][DW-1:0]   rem;
      logic [LANES-1:0][Q_W-1:0]  quo;
      logic [RT_W:0]              d;
   } dv_stage_type;

   dv_stage_type st_ff [NS];
   dv_stage_type st_in [NS];
   logic         v_ff  [NS];
   logic         adv   [NS+1];

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      logic [RT_W:0]   d;
      logic [DW-1:0]   num;
      logic [DW-1:0]   sh;
      d = {in_root, 1'b0};
      st_in[0].degen = in_side.degen;
      st_in[0].neg   = in_side.neg;
      st_in[0].d     = d;
      st_in[0].quo   = '0;
      for (int l = 0; l < LANES; l++) begin
         num = DW'({in_side.mag[l], {FRAC_BITS{1'b0}}}) + DW'(in_root);
         st_in[0].rem[l] = num;
         st_in[0].ovf[l] = num >= (DW'(d) << Q_W);
      end
      for (int j = 1; j < NS; j++) begin
         st_in[j] = st_ff[j-1];
         sh = DW'(st_ff[j-1].d) << (Q_W - j);
         for (int l = 0; l < LANES; l++) begin
            if (st_ff[j-1].rem[l] >= sh) begin
               st_in[j].rem[l]         = st_ff[j-1].rem[l] - sh;
               st_in[j].quo[l][Q_W-j]  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready      = adv[0];
   assign out_valid     = v_ff[NS-1];
   assign out_quo.degen = st_ff[NS-1].degen;
   assign out_quo.neg   = st_ff[NS-1].neg;
   assign out_quo.ovf   = st_ff[NS-1].ovf;
   assign out_quo.quo   = st_ff[NS-1].quo;

endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// Values are Q1.14 in this build. Throughput: one request per cycle while
// the response channel takes results; every stage is elastic, so bubbles
// close up and a request is taken while a finished result waits at the
// output if a bubble remains upstream. The depth is set by the square root
// and divider pipelines. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Shepperd's method: pivot selection, square root of the pivot, and scaling
// of the four components with rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
   input logic        clock,
   input logic        reset,
   rmq_req_if.sink    req_chan,
   rmq_rsp_if.source  rsp_chan
);
   import rmq_pkg::*;

   logic              a_v_ff;
   logic [SP_W-1:0]   a_s_ff;
   rmq_side_type      a_side_ff;
   logic [SP_W-1:0]   a_s_in;
   rmq_side_type      a_side_in;
   logic              a_ready;

   logic              sq_ready;
   logic              sq_valid;
   logic [RT_W-1:0]   sq_root;
   rmq_side_type      sq_side;
   logic              dv_ready;
   logic              dv_valid;
   rmq_quo_type       dv_quo;

   logic                        o_v_ff;
   logic [LANES-1:0][OUT_W-1:0] o_q_ff;
   logic                        o_degen_ff;
   logic [LANES-1:0][OUT_W-1:0] o_q_in;
   logic                        o_ready;

   always_comb begin
      logic signed [PIV_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
      logic signed [PIV_W-1:0] trace, piv, cabs;
      logic signed [PIV_W-1:0] c [LANES];
      a00 = PIV_W'(req_chan.m_r0c0);
      a01 = PIV_W'(req_chan.m_r0c1);
      a02 = PIV_W'(req_chan.m_r0c2);
      a10 = PIV_W'(req_chan.m_r1c0);
      a11 = PIV_W'(req_chan.m_r1c1);
      a12 = PIV_W'(req_chan.m_r1c2);
      a20 = PIV_W'(req_chan.m_r2c0);
      a21 = PIV_W'(req_chan.m_r2c1);
      a22 = PIV_W'(req_chan.m_r2c2);
      trace = a00 + a11 + a22;
      if (trace > 0) begin
         piv  = trace + ONE;
         c[0] = a21 - a12;
         c[1] = a02 - a20;
         c[2] = a10 - a01;
         c[3] = piv;
      end else if (a00 > a11 && a00 > a22) begin
         piv  = ONE + a00 - a11 - a22;
         c[0] = piv;
         c[1] = a10 + a01;
         c[2] = a02 + a20;
         c[3] = a21 - a12;
      end else if (a11 > a22) begin
         piv  = ONE + a11 - a00 - a22;
         c[0] = a01 + a10;
         c[1] = piv;
         c[2] = a12 + a21;
         c[3] = a02 - a20;
      end else begin
         piv  = ONE + a22 - a00 - a11;
         c[0] = a02 + a20;
         c[1] = a12 + a21;
         c[2] = piv;
         c[3] = a10 - a01;
      end
      a_side_in.degen = piv <= 0;
      for (int l = 0; l < LANES; l++) begin
         cabs = c[l][PIV_W-1] ? -c[l] : c[l];
         a_side_in.neg[l] = c[l][PIV_W-1];
         a_side_in.mag[l] = cabs[MAG_W-1:0];
      end
      a_s_in = SP_W'({piv[MAG_W-1:0], {FRAC_BITS{1'b0}}});
   end

   assign a_ready        = !a_v_ff || sq_ready;
   assign req_chan.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_ready) begin
         a_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_s_ff    <= a_s_in;
         a_side_ff <= a_side_in;
      end
   end

   rmq_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_v_ff),
      .in_ready  (sq_ready),
      .in_s      (a_s_ff),
      .in_side   (a_side_ff),
      .out_valid (sq_valid),
      .out_ready (dv_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (dv_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_ready (o_ready),
      .out_quo   (dv_quo)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (dv_quo.degen) begin
            o_q_in[l] = '0;
         end else if (dv_quo.neg[l]) begin
            if (dv_quo.ovf[l] || dv_quo.quo[l] > Q_LIM) begin
               o_q_in[l] = NEG_MIN;
            end else begin
               o_q_in[l] = OUT_W'(Q_W'(0) - dv_quo.quo[l]);
            end
         end else begin
            if (dv_quo.ovf[l] || dv_quo.quo[l] >= Q_LIM) begin
               o_q_in[l] = POS_MAX;
            end else begin
               o_q_in[l] = dv_quo.quo[l][OUT_W-1:0];
            end
         end
      end
   end

   assign o_ready = !o_v_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_ready) begin
         o_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready) begin
         o_q_ff     <= o_q_in;
         o_degen_ff <= dv_quo.degen;
      end
   end

   assign rsp_chan.valid      = o_v_ff;
   assign rsp_chan.quat_x     = o_q_ff[0];
   assign rsp_chan.quat_y     = o_q_ff[1];
   assign rsp_chan.quat_z     = o_q_ff[2];
   assign rsp_chan.quat_w     = o_q_ff[3];
   assign rsp_chan.degenerate = o_degen_ff;

endmodule
